// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int DATA_W   = 32;
   localparam int OCC_W    = 5;

   typedef enum logic [1:0] {
      FUNC_PUSH_FRONT = 2'd0,
      FUNC_PUSH_BACK  = 2'd1,
      FUNC_POP_FRONT  = 2'd2,
      FUNC_POP_BACK   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      func_type                   func;
      logic signed [DATA_W-1:0]   push_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   pop_value;
      status_type                 status;
      logic        [OCC_W-1:0]    occupancy;
   } rsp_type;

endpackage

// ===== hw/rtl/double_ended_queue.sv =====
// Result: a transaction accepted at a clock edge gives its result with rsp_strobe high
// in the cycle after that edge, as the entry RAM read and the status are registered.
// Throughput: one transaction per cycle; busy stays low, every cycle can start one.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active high) empties the queue: head and count go to zero;
// the entry RAM is not cleared, unwritten entries are never read.
module double_ended_queue
   import deq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   logic [DATA_W-1:0] mem [CAPACITY];

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              strobe_ff;
   logic              pop_ok_ff;
   status_type        status_ff, status_in;
   logic [OCC_W-1:0]  occ_ff;
   logic [DATA_W-1:0] rd_data_ff;

   logic              accept;
   logic              is_full, is_empty;
   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_idx, rd_idx;
   logic [IDX_W-1:0]  head_dec, head_inc, back_slot, last_slot;
   logic [SUM_W-1:0]  back_sum, last_sum;
   logic [CNT_W+OCC_W-1:0] occ_wide;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff >= CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // Ring index arithmetic, one compare-and-subtract for the wrap.
   assign head_dec = (head_ff == '0) ? IDX_W'(CAPACITY - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;
   assign back_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign last_sum = back_sum - 1'b1;
   always_comb begin
      back_slot = (back_sum >= SUM_W'(CAPACITY)) ?
                  IDX_W'(back_sum - SUM_W'(CAPACITY)) : back_sum[IDX_W-1:0];
      last_slot = (last_sum >= SUM_W'(CAPACITY)) ?
                  IDX_W'(last_sum - SUM_W'(CAPACITY)) : last_sum[IDX_W-1:0];
   end

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = STATUS_OK;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_idx    = head_dec;
      rd_idx    = head_ff;
      if (accept) begin
         unique case (req_payload.func)
            FUNC_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_idx   = head_dec;
                  head_in  = head_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            FUNC_PUSH_BACK: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_idx   = back_slot;
                  count_in = count_ff + 1'b1;
               end
            end
            FUNC_POP_FRONT: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_idx   = head_ff;
                  head_in  = head_inc;
                  count_in = count_ff - 1'b1;
               end
            end
            FUNC_POP_BACK: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_idx   = last_slot;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   // A push's write lands in the entry RAM at its own edge, before a following pop's read
   // samples it, so back-to-back push then pop of one slot needs no bypass.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= req_payload.push_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign occ_wide = (CNT_W + OCC_W)'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         pop_ok_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         strobe_ff <= accept;
         pop_ok_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         occ_ff    <= occ_wide[OCC_W-1:0];
      end
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_payload.pop_value = pop_ok_ff ? rd_data_ff : '0;
   assign rsp_payload.status    = status_ff;
   assign rsp_payload.occupancy = occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= IDX_W'(CAPACITY - 1))
      else $error("head index out of range");

   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy))
      else $error("result without a transaction");

   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == STATUS_FULL) |-> count_ff == CNT_W'(CAPACITY))
      else $error("full status with free entries");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == STATUS_EMPTY)
         |-> (rsp_payload.pop_value == '0 && count_ff == '0))
      else $error("empty status with data or entries");

endmodule
